@@ design/capsule_pair_collision_test_assert.svh @@
// Assertion macros for the capsule pair collision test checker.
// Expects signals named clock and reset in the scope of use.
`ifndef CAPSULE_PAIR_COLLISION_TEST_ASSERT_SVH
`define CAPSULE_PAIR_COLLISION_TEST_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define CPCT_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("capsule pair collision test: assertion failed");

// Next-cycle implication, ignored while reset is high.
`define CPCT_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("capsule pair collision test: assertion failed");

// Next-cycle implication that also holds across reset.
`define CPCT_ASSERT_ALWAYS(label, pre, post) \
   label: assert property (@(posedge clock) (pre) |=> (post)) \
      else $error("capsule pair collision test: reset assertion failed");

`endif

@@ design/cpct_pkg.sv @@
// Shared constants and types for the capsule pair collision test.
// No dependencies.
package cpct_pkg;

   localparam int FRAC_BITS   = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int LIMIT_W     = 32;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd2814749767;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REF_START_X     = 3'd0,
      CSR_REF_START_Y     = 3'd1,
      CSR_REF_START_Z     = 3'd2,
      CSR_REF_END_X       = 3'd3,
      CSR_REF_END_Y       = 3'd4,
      CSR_REF_END_Z       = 3'd5,
      CSR_REF_RADIUS      = 3'd6,
      CSR_NEAR_ZERO_LIMIT = 3'd7
   } csr_index_type;

endpackage

@@ design/cpct_dot.sv @@
// Three-stage dot product unit: segment differences, per-axis products, sums.
// Depends on cpct_pkg.
module cpct_dot
   import cpct_pkg::*;
#(
   parameter int W     = 24,
   parameter int TAG_W = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic signed [W-1:0]   p0 [3],
   input  logic signed [W-1:0]   p1 [3],
   input  logic signed [W-1:0]   q0 [3],
   input  logic signed [W-1:0]   q1 [3],
   input  logic [TAG_W-1:0]      in_tag,
   output logic                  out_valid,
   output logic signed [2*W+3:0] a,
   output logic signed [2*W+3:0] b,
   output logic signed [2*W+3:0] c,
   output logic signed [2*W+3:0] d,
   output logic signed [2*W+3:0] e,
   output logic [TAG_W-1:0]      out_tag
);
   localparam int DW    = W + 1;
   localparam int PRODW = 2 * DW;
   localparam int DOTW  = PRODW + 2;

   logic signed [DW-1:0]    u_ff [3], v_ff [3], w_ff [3];
   logic signed [PRODW-1:0] uu_ff [3], uv_ff [3], vv_ff [3], uw_ff [3], vw_ff [3];
   logic signed [DOTW-1:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [TAG_W-1:0]        tag1_ff, tag2_ff, tag3_ff;
   logic                    vld1_ff, vld2_ff, vld3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            u_ff[i]  <= DW'(p1[i]) - DW'(p0[i]);
            v_ff[i]  <= DW'(q1[i]) - DW'(q0[i]);
            w_ff[i]  <= DW'(p0[i]) - DW'(q0[i]);
            uu_ff[i] <= u_ff[i] * u_ff[i];
            uv_ff[i] <= u_ff[i] * v_ff[i];
            vv_ff[i] <= v_ff[i] * v_ff[i];
            uw_ff[i] <= u_ff[i] * w_ff[i];
            vw_ff[i] <= v_ff[i] * w_ff[i];
         end
         a_ff    <= DOTW'(uu_ff[0]) + DOTW'(uu_ff[1]) + DOTW'(uu_ff[2]);
         b_ff    <= DOTW'(uv_ff[0]) + DOTW'(uv_ff[1]) + DOTW'(uv_ff[2]);
         c_ff    <= DOTW'(vv_ff[0]) + DOTW'(vv_ff[1]) + DOTW'(vv_ff[2]);
         d_ff    <= DOTW'(uw_ff[0]) + DOTW'(uw_ff[1]) + DOTW'(uw_ff[2]);
         e_ff    <= DOTW'(vw_ff[0]) + DOTW'(vw_ff[1]) + DOTW'(vw_ff[2]);
         tag1_ff <= in_tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   assign a         = a_ff;
   assign b         = b_ff;
   assign c         = c_ff;
   assign d         = d_ff;
   assign e         = e_ff;
   assign out_tag   = tag3_ff;
   assign out_valid = vld3_ff;

endmodule

@@ design/cpct_solve.sv @@
// Six-stage solver for the clamped segment parameters as numerator and
// denominator pairs in units of 2^-48. Depends on cpct_pkg.
module cpct_solve
   import cpct_pkg::*;
#(
   parameter int W     = 24,
   parameter int TAG_W = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic signed [2*W+3:0]  a,
   input  logic signed [2*W+3:0]  b,
   input  logic signed [2*W+3:0]  c,
   input  logic signed [2*W+3:0]  d,
   input  logic signed [2*W+3:0]  e,
   input  logic [LIMIT_W-1:0]     lim,
   input  logic [TAG_W-1:0]       in_tag,
   output logic                   out_valid,
   output logic signed [4*W+9:0]  s_num,
   output logic signed [4*W+9:0]  s_den,
   output logic signed [4*W+9:0]  t_num,
   output logic signed [4*W+9:0]  t_den,
   output logic [TAG_W-1:0]       out_tag
);
   localparam int DOTW  = 2 * W + 4;
   localparam int WW    = 2 * DOTW + 2;
   localparam int HB    = DOTW / 2;
   localparam int PPW   = 2 * HB + 2;
   localparam int NPROD = 6;

   logic signed [DOTW-1:0] mul_x [NPROD], mul_y [NPROD];
   logic signed [HB-1:0]   x_hi [NPROD], y_hi [NPROD];
   logic signed [HB:0]     x_lo [NPROD], y_lo [NPROD];

   logic signed [PPW-1:0]  hh4_ff [NPROD], hl4_ff [NPROD], lh4_ff [NPROD], ll4_ff [NPROD];
   logic signed [DOTW-1:0] a4_ff, b4_ff, c4_ff, d4_ff, e4_ff;
   logic signed [WW-1:0]   prod5_ff [NPROD];
   logic signed [DOTW-1:0] a5_ff, b5_ff, c5_ff, d5_ff, e5_ff;
   logic signed [WW-1:0]   f_ff, sn0_ff, tn0_ff;
   logic signed [DOTW-1:0] a6_ff, b6_ff, c6_ff, d6_ff, e6_ff;
   logic signed [WW-1:0]   sn7_ff, sd7_ff, tn7_ff, td7_ff;
   logic signed [DOTW-1:0] a7_ff, b7_ff, d7_ff;
   logic signed [WW-1:0]   sn8_ff, sd8_ff, tn8_ff, td8_ff;
   logic signed [DOTW:0]   m8_ff;
   logic signed [DOTW-1:0] a8_ff;
   logic                   fix8_ff;
   logic signed [WW-1:0]   sn9_ff, sd9_ff, tn9_ff, td9_ff;
   logic [TAG_W-1:0]       tag4_ff, tag5_ff, tag6_ff, tag7_ff, tag8_ff, tag9_ff;
   logic                   vld4_ff, vld5_ff, vld6_ff, vld7_ff, vld8_ff, vld9_ff;

   logic signed [WW-1:0]   lim_w;
   logic signed [WW-1:0]   sn7_in, sd7_in, tn7_in, td7_in;
   logic signed [WW-1:0]   tn8_in;
   logic signed [DOTW:0]   m8_in;
   logic                   fix8_in;
   logic signed [WW-1:0]   sn9_in, sd9_in;

   assign lim_w = {{(WW-LIMIT_W){1'b0}}, lim};

   // The six wide products are a*c, b*b, b*e, c*d, a*e and b*d. Each one is
   // split into half-width partial products so no single multiplier is wide.
   always_comb begin
      mul_x[0] = a;  mul_y[0] = c;
      mul_x[1] = b;  mul_y[1] = b;
      mul_x[2] = b;  mul_y[2] = e;
      mul_x[3] = c;  mul_y[3] = d;
      mul_x[4] = a;  mul_y[4] = e;
      mul_x[5] = b;  mul_y[5] = d;
      for (int j = 0; j < NPROD; j++) begin
         x_hi[j] = $signed(mul_x[j][DOTW-1:HB]);
         y_hi[j] = $signed(mul_y[j][DOTW-1:HB]);
         x_lo[j] = $signed({1'b0, mul_x[j][HB-1:0]});
         y_lo[j] = $signed({1'b0, mul_y[j][HB-1:0]});
      end
   end

   // Near-parallel pins the reference parameter; otherwise the first clamp.
   always_comb begin
      sn7_in = sn0_ff;
      sd7_in = f_ff;
      tn7_in = tn0_ff;
      td7_in = f_ff;
      if (f_ff < lim_w) begin
         sn7_in = '0;
         sd7_in = WW'(1) <<< (2 * FRAC_BITS);
         tn7_in = WW'(e6_ff) <<< FRAC_BITS;
         td7_in = WW'(c6_ff) <<< FRAC_BITS;
      end else if (sn0_ff < 0) begin
         sn7_in = '0;
         tn7_in = WW'(e6_ff) <<< FRAC_BITS;
         td7_in = WW'(c6_ff) <<< FRAC_BITS;
      end else if (sn0_ff > f_ff) begin
         sn7_in = f_ff;
         tn7_in = (WW'(e6_ff) + WW'(b6_ff)) <<< FRAC_BITS;
         td7_in = WW'(c6_ff) <<< FRAC_BITS;
      end
   end

   // Clamping the other parameter asks for a new reference numerator.
   always_comb begin
      tn8_in  = tn7_ff;
      m8_in   = '0;
      fix8_in = 1'b0;
      if (tn7_ff < 0) begin
         tn8_in  = '0;
         m8_in   = -(DOTW+1)'(d7_ff);
         fix8_in = 1'b1;
      end else if (tn7_ff > td7_ff) begin
         tn8_in  = td7_ff;
         m8_in   = (DOTW+1)'(b7_ff) - (DOTW+1)'(d7_ff);
         fix8_in = 1'b1;
      end
   end

   always_comb begin
      sn9_in = sn8_ff;
      sd9_in = sd8_ff;
      if (fix8_ff) begin
         if (m8_ff < 0) begin
            sn9_in = '0;
         end else if (m8_ff > (DOTW+1)'(a8_ff)) begin
            sn9_in = sd8_ff;
         end else begin
            sn9_in = WW'(m8_ff) <<< FRAC_BITS;
            sd9_in = WW'(a8_ff) <<< FRAC_BITS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
         vld7_ff <= 1'b0;
         vld8_ff <= 1'b0;
         vld9_ff <= 1'b0;
      end else if (en) begin
         vld4_ff <= in_valid;
         vld5_ff <= vld4_ff;
         vld6_ff <= vld5_ff;
         vld7_ff <= vld6_ff;
         vld8_ff <= vld7_ff;
         vld9_ff <= vld8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < NPROD; j++) begin
            hh4_ff[j] <= PPW'(x_hi[j]) * PPW'(y_hi[j]);
            hl4_ff[j] <= PPW'(x_hi[j]) * PPW'(y_lo[j]);
            lh4_ff[j] <= PPW'(x_lo[j]) * PPW'(y_hi[j]);
            ll4_ff[j] <= PPW'(x_lo[j]) * PPW'(y_lo[j]);
            prod5_ff[j] <= (WW'(hh4_ff[j]) <<< (2 * HB)) +
                           ((WW'(hl4_ff[j]) + WW'(lh4_ff[j])) <<< HB) +
                           WW'(ll4_ff[j]);
         end
         a4_ff   <= a;
         b4_ff   <= b;
         c4_ff   <= c;
         d4_ff   <= d;
         e4_ff   <= e;
         tag4_ff <= in_tag;

         a5_ff   <= a4_ff;
         b5_ff   <= b4_ff;
         c5_ff   <= c4_ff;
         d5_ff   <= d4_ff;
         e5_ff   <= e4_ff;
         tag5_ff <= tag4_ff;

         f_ff    <= prod5_ff[0] - prod5_ff[1];
         sn0_ff  <= prod5_ff[2] - prod5_ff[3];
         tn0_ff  <= prod5_ff[4] - prod5_ff[5];
         a6_ff   <= a5_ff;
         b6_ff   <= b5_ff;
         c6_ff   <= c5_ff;
         d6_ff   <= d5_ff;
         e6_ff   <= e5_ff;
         tag6_ff <= tag5_ff;

         sn7_ff  <= sn7_in;
         sd7_ff  <= sd7_in;
         tn7_ff  <= tn7_in;
         td7_ff  <= td7_in;
         a7_ff   <= a6_ff;
         b7_ff   <= b6_ff;
         d7_ff   <= d6_ff;
         tag7_ff <= tag6_ff;

         sn8_ff  <= sn7_ff;
         sd8_ff  <= sd7_ff;
         tn8_ff  <= tn8_in;
         td8_ff  <= td7_ff;
         m8_ff   <= m8_in;
         fix8_ff <= fix8_in;
         a8_ff   <= a7_ff;
         tag8_ff <= tag7_ff;

         sn9_ff  <= sn9_in;
         sd9_ff  <= sd9_in;
         tn9_ff  <= tn8_ff;
         td9_ff  <= td8_ff;
         tag9_ff <= tag8_ff;
      end
   end

   assign s_num     = sn9_ff;
   assign s_den     = sd9_ff;
   assign t_num     = tn9_ff;
   assign t_den     = td9_ff;
   assign out_tag   = tag9_ff;
   assign out_valid = vld9_ff;

endmodule

@@ design/cpct_div.sv @@
// Pipelined restoring divider giving floor(n * 2^24 / d), one quotient bit
// per stage, with the snap and edge cases decided up front. Depends on cpct_pkg.
module cpct_div
   import cpct_pkg::*;
#(
   parameter int NW    = 106,
   parameter int TAG_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [NW-1:0] num,
   input  logic signed [NW-1:0] den,
   input  logic [LIMIT_W-1:0]   lim,
   input  logic [TAG_W-1:0]     in_tag,
   output logic                 out_valid,
   output logic [FRAC_BITS:0]   quo,
   output logic [TAG_W-1:0]     out_tag
);
   localparam int QB = FRAC_BITS;

   logic signed [NW-1:0] lim_w, abs_n;
   logic                 zero_in, full_in;

   logic [NW-2:0]        rem_ff  [QB+1];
   logic [NW-2:0]        den_ff  [QB+1];
   logic [QB-1:0]        q_ff    [QB+1];
   logic                 zero_ff [QB+1];
   logic                 full_ff [QB+1];
   logic [TAG_W-1:0]     tag_ff  [QB+1];
   logic                 vld_ff  [QB+1];

   assign lim_w   = {{(NW-LIMIT_W){1'b0}}, lim};
   assign abs_n   = (num < 0) ? -num : num;
   assign zero_in = (abs_n < lim_w) || (den <= 0) || (num <= 0);
   assign full_in = (num >= den);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // A remainder only matters in the regular case, where 0 < n < d.
         rem_ff[0]  <= (zero_in || full_in) ? '0 : num[NW-2:0];
         den_ff[0]  <= den[NW-2:0];
         q_ff[0]    <= '0;
         zero_ff[0] <= zero_in;
         full_ff[0] <= full_in;
         tag_ff[0]  <= in_tag;
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_step
      logic [NW-1:0] r2;
      logic          ge;
      assign r2 = {rem_ff[k], 1'b0};
      assign ge = (r2 >= {1'b0, den_ff[k]});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= ge ? (NW-1)'(r2 - {1'b0, den_ff[k]}) : r2[NW-2:0];
            den_ff[k+1]  <= den_ff[k];
            q_ff[k+1]    <= {q_ff[k][QB-2:0], ge};
            zero_ff[k+1] <= zero_ff[k];
            full_ff[k+1] <= full_ff[k];
            tag_ff[k+1]  <= tag_ff[k];
         end
      end
   end

   assign quo       = zero_ff[QB] ? '0 :
                      full_ff[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, q_ff[QB]};
   assign out_tag   = tag_ff[QB];
   assign out_valid = vld_ff[QB];

endmodule

@@ design/cpct_point.sv @@
// Five-stage back end: closest points from the parameters, squared
// distance and the collide compare. Its last stage is the result register.
// Depends on cpct_pkg.
module cpct_point
   import cpct_pkg::*;
#(
   parameter int W = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [FRAC_BITS:0]   sc,
   input  logic [FRAC_BITS:0]   tc,
   input  logic signed [W-1:0]  p0 [3],
   input  logic signed [W-1:0]  p1 [3],
   input  logic signed [W-1:0]  q0 [3],
   input  logic signed [W-1:0]  q1 [3],
   input  logic [W-1:0]         rsum,
   output logic                 out_valid,
   output logic signed [W-1:0]  near_ref [3],
   output logic signed [W-1:0]  near_other [3],
   output logic [2*W+1:0]       distance_sq,
   output logic                 collide
);
   localparam int DW  = W + 1;
   localparam int PW  = DW + FRAC_BITS + 2;
   localparam int SQW = 2 * (W + 2);
   localparam int SUMW = SQW + 2;

   logic signed [PW-1:0]   pu_ff [3], pv_ff [3];
   logic signed [W-1:0]    q0a_ff [3];
   logic [W-1:0]           rs1_ff, rs2_ff;
   logic signed [W:0]      pp_ff [3], qq_ff [3], pp3_ff [3], qq3_ff [3];
   logic signed [SQW-1:0]  sq_ff [3];
   logic [2*W-1:0]         rr_ff, rr4_ff;
   logic signed [W:0]      pp4_ff [3], qq4_ff [3];
   logic [SUMW-1:0]        dist_ff;
   logic signed [W-1:0]    nr_ff [3], no_ff [3];
   logic [2*W+1:0]         dsq_ff;
   logic                   col_ff;
   logic                   vld1_ff, vld2_ff, vld3_ff, vld4_ff, vld5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            pu_ff[i]  <= PW'(DW'(p1[i]) - DW'(p0[i])) * PW'($signed({1'b0, sc}));
            pv_ff[i]  <= PW'(DW'(q1[i]) - DW'(q0[i])) * PW'($signed({1'b0, tc}));
            q0a_ff[i] <= q0[i];
            // Arithmetic shift drops the fraction toward minus infinity.
            pp_ff[i]  <= (W+1)'(p0[i]) + (W+1)'(pu_ff[i] >>> FRAC_BITS);
            qq_ff[i]  <= (W+1)'(q0a_ff[i]) + (W+1)'(pv_ff[i] >>> FRAC_BITS);
            sq_ff[i]  <= ((W+2)'(pp_ff[i]) - (W+2)'(qq_ff[i])) *
                         ((W+2)'(pp_ff[i]) - (W+2)'(qq_ff[i]));
            pp3_ff[i] <= pp_ff[i];
            qq3_ff[i] <= qq_ff[i];
            pp4_ff[i] <= pp3_ff[i];
            qq4_ff[i] <= qq3_ff[i];
            nr_ff[i]  <= pp4_ff[i][W-1:0];
            no_ff[i]  <= qq4_ff[i][W-1:0];
         end
         rs1_ff  <= rsum;
         rs2_ff  <= rs1_ff;
         rr_ff   <= (2*W)'(rs2_ff) * (2*W)'(rs2_ff);
         rr4_ff  <= rr_ff;
         dist_ff <= SUMW'(unsigned'(sq_ff[0])) + SUMW'(unsigned'(sq_ff[1])) +
                    SUMW'(unsigned'(sq_ff[2]));
         dsq_ff  <= dist_ff[2*W+1:0];
         col_ff  <= (dist_ff < SUMW'(rr4_ff));
      end
   end

   assign near_ref    = nr_ff;
   assign near_other  = no_ff;
   assign distance_sq = dsq_ff;
   assign collide     = col_ff;
   assign out_valid   = vld5_ff;

endmodule

@@ design/capsule_pair_collision_test.sv @@
// Capsule pair collision test: the reference capsule sits in the csr_
// registers, each request carries another capsule, and each request yields
// one response with both closest points, their squared distance and a
// collide flag. The pipeline takes one request per clock unless a response
// is stalled; each request passes 3 dot product stages, 6 solver stages
// (partial products, product sums, then the clamps), 25 divider stages (an
// entry stage and one per quotient bit) and 5 point and distance stages.
// A stalled response holds the whole pipeline. Write registers only while
// no request is in flight. Depends on cpct_pkg and the cpct_ submodules.
module capsule_pair_collision_test
   import cpct_pkg::*;
#(
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // other_start_x/y/z, other_end_x/y/z, other_radius, zero fill
   input  logic [((7*COORD_WIDTH+6)/8)*8-1:0]  req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // near_ref_x/y/z, near_other_x/y/z, distance_sq, collide, zero fill
   output logic [((8*COORD_WIDTH+10)/8)*8-1:0] rsp_tdata
);
   localparam int W      = COORD_WIDTH;
   localparam int WW     = 4 * W + 10;
   localparam int RSP_W  = ((8*W+10)/8)*8;
   localparam int DIST_W = 2 * W + 2;
   localparam int SIDE_W = 7 * W;

   logic signed [W-1:0]  p0_ff [3], p1_ff [3];
   logic [W-2:0]         radius_ff;
   logic [LIMIT_W-1:0]   limit_ff;

   logic signed [W-1:0]  q0_in [3], q1_in [3];
   logic [W-2:0]         other_radius;
   logic [SIDE_W-1:0]    side_in, side_dot, side_solve;
   logic                 en;

   logic                 dot_valid, solve_valid, div_valid, div_t_valid;
   logic signed [2*W+3:0] dot_a, dot_b, dot_c, dot_d, dot_e;
   logic signed [WW-1:0] s_num, s_den, t_num, t_den;
   logic [FRAC_BITS:0]   sc, tc;
   logic [3*W-1:0]       tag_s;
   logic [4*W-1:0]       tag_t;
   logic signed [W-1:0]  q0_d [3], q1_d [3];
   logic [W-1:0]         rsum_d;

   logic signed [W-1:0]  near_ref [3], near_other [3];
   logic [DIST_W-1:0]    distance_sq;
   logic                 collide;

   // Everything advances unless a finished response is being held.
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            p0_ff[i] <= '0;
            p1_ff[i] <= '0;
         end
         radius_ff <= '0;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_REF_START_X:     p0_ff[0]  <= csr_wdata[W-1:0];
            CSR_REF_START_Y:     p0_ff[1]  <= csr_wdata[W-1:0];
            CSR_REF_START_Z:     p0_ff[2]  <= csr_wdata[W-1:0];
            CSR_REF_END_X:       p1_ff[0]  <= csr_wdata[W-1:0];
            CSR_REF_END_Y:       p1_ff[1]  <= csr_wdata[W-1:0];
            CSR_REF_END_Z:       p1_ff[2]  <= csr_wdata[W-1:0];
            CSR_REF_RADIUS:      radius_ff <= csr_wdata[W-2:0];
            CSR_NEAR_ZERO_LIMIT: limit_ff  <= csr_wdata[LIMIT_W-1:0];
            default:             limit_ff  <= limit_ff;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q0_in[i] = req_tdata[i*W +: W];
         q1_in[i] = req_tdata[(i+3)*W +: W];
      end
   end
   assign other_radius = req_tdata[6*W +: W-1];

   assign side_in = {W'(radius_ff) + W'(other_radius),
                     q1_in[2], q1_in[1], q1_in[0], q0_in[2], q0_in[1], q0_in[0]};

   cpct_dot #(.W(W), .TAG_W(SIDE_W)) u_dot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .p0        (p0_ff),
      .p1        (p1_ff),
      .q0        (q0_in),
      .q1        (q1_in),
      .in_tag    (side_in),
      .out_valid (dot_valid),
      .a         (dot_a),
      .b         (dot_b),
      .c         (dot_c),
      .d         (dot_d),
      .e         (dot_e),
      .out_tag   (side_dot)
   );

   cpct_solve #(.W(W), .TAG_W(SIDE_W)) u_solve (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dot_valid),
      .a         (dot_a),
      .b         (dot_b),
      .c         (dot_c),
      .d         (dot_d),
      .e         (dot_e),
      .lim       (limit_ff),
      .in_tag    (side_dot),
      .out_valid (solve_valid),
      .s_num     (s_num),
      .s_den     (s_den),
      .t_num     (t_num),
      .t_den     (t_den),
      .out_tag   (side_solve)
   );

   cpct_div #(.NW(WW), .TAG_W(3*W)) u_div_s (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (solve_valid),
      .num       (s_num),
      .den       (s_den),
      .lim       (limit_ff),
      .in_tag    (side_solve[3*W-1:0]),
      .out_valid (div_valid),
      .quo       (sc),
      .out_tag   (tag_s)
   );

   cpct_div #(.NW(WW), .TAG_W(4*W)) u_div_t (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (solve_valid),
      .num       (t_num),
      .den       (t_den),
      .lim       (limit_ff),
      .in_tag    (side_solve[SIDE_W-1:3*W]),
      .out_valid (div_t_valid),
      .quo       (tc),
      .out_tag   (tag_t)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q0_d[i] = tag_s[i*W +: W];
         q1_d[i] = tag_t[i*W +: W];
      end
   end
   assign rsum_d = tag_t[3*W +: W];

   cpct_point #(.W(W)) u_point (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (div_valid && div_t_valid),
      .sc          (sc),
      .tc          (tc),
      .p0          (p0_ff),
      .p1          (p1_ff),
      .q0          (q0_d),
      .q1          (q1_d),
      .rsum        (rsum_d),
      .out_valid   (rsp_tvalid),
      .near_ref    (near_ref),
      .near_other  (near_other),
      .distance_sq (distance_sq),
      .collide     (collide)
   );

   assign rsp_tdata = RSP_W'({collide, distance_sq,
                              near_other[2], near_other[1], near_other[0],
                              near_ref[2], near_ref[1], near_ref[0]});

endmodule

@@ design/cpct_checker.sv @@
// Port-level checker for the capsule pair collision test, bound to the top.
// Depends on capsule_pair_collision_test_assert.svh.
`include "capsule_pair_collision_test_assert.svh"

module cpct_checker #(
   parameter int RSP_W = 200
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);
   logic rsp_stall;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   `CPCT_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid)
   `CPCT_ASSERT_NEXT(a_rsp_data_hold, rsp_stall, $stable(rsp_tdata))
   // A held response freezes the pipeline, so no request may enter.
   `CPCT_ASSERT_NOW(a_no_accept_on_stall, rsp_stall, !req_tready)
   `CPCT_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_tvalid)

endmodule

bind capsule_pair_collision_test cpct_checker #(
   .RSP_W(((8*COORD_WIDTH+10)/8)*8)
) u_cpct_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
